// ===== design/mpo_pkg.sv =====
// ----------------------------------------------------------------------------
// mpo_pkg
// Shared types and constants of the perturb-and-observe tracker.
// ----------------------------------------------------------------------------
package mpo_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int REG_W      = 12;
    localparam int STEP_W     = 13;
    localparam int PROD_W     = 33;
    localparam int RUN_W      = 2;
    localparam int LEVEL_W    = 12;

    localparam int OP_QUEUE_DEPTH  = 2;
    localparam int OUT_QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DAC_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAC_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_MODE    = 3'd5;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_DECIDE = 1'b1;

    localparam logic PIN_MODE_SS = 1'b0;
    localparam logic PIN_MODE_EN = 1'b1;

    localparam logic [REG_W-1:0] RST_DAC_LOW   = 12'd0;
    localparam logic [REG_W-1:0] RST_DAC_HIGH  = 12'd4095;
    localparam logic [REG_W-1:0] RST_STEP_LOW  = 12'd1;
    localparam logic [REG_W-1:0] RST_STEP_HIGH = 12'd8;
    localparam logic [REG_W-1:0] RST_START     = 12'd2048;

    localparam logic [RUN_W-1:0] RUN_MAX = 2'd3;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] shunt_sample;
        logic        [15:0] bus_sample;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] drive_level;
        logic [STEP_W-1:0]  step_now;
        logic               moving_up;
        logic               power_fell;
    } t_out_item;

    typedef struct packed {
        logic                     decide;
        logic signed [PROD_W-1:0] product;
    } t_op;

    typedef struct packed {
        logic [REG_W-1:0] dac_low;
        logic [REG_W-1:0] dac_high;
        logic [REG_W-1:0] step_low;
        logic [REG_W-1:0] step_high;
        logic             pin_mode;
    } t_cfg;

endpackage

// ===== design/mpo_queue.sv =====
// ----------------------------------------------------------------------------
// mpo_queue
// Small first-in first-out queue in flip-flops, push and pop in one cycle.
// ----------------------------------------------------------------------------
module mpo_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/mpo_front.sv =====
// ----------------------------------------------------------------------------
// mpo_front
// Accepts input transactions, classifies them and forms the power product.
// ----------------------------------------------------------------------------
module mpo_front (
    input  logic              i_push,
    input  mpo_pkg::t_in_item i_item,
    input  logic              i_queue_full,
    output logic              o_op_push,
    output mpo_pkg::t_op      o_op
);
    import mpo_pkg::*;

    logic signed [16:0]       bus_signed;
    logic signed [PROD_W-1:0] product;

    assign bus_signed = $signed({1'b0, i_item.bus_sample});
    assign product    = i_item.shunt_sample * bus_signed;

    assign o_op_push  = i_push && !i_queue_full;

    always_comb begin
        o_op.decide  = (i_item.req_type == REQ_DECIDE);
        o_op.product = (i_item.req_type == REQ_SAMPLE) ? product : '0;
    end

endmodule

// ===== design/mpo_back.sv =====
// ----------------------------------------------------------------------------
// mpo_back
// Holds the tracker state and limits; runs one queued operation per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module mpo_back #(
    parameter int SUM_WIDTH = 48,
    parameter int DAC_BITS  = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mpo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mpo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_op_valid,
    input  mpo_pkg::t_op                   i_op,
    input  logic                           i_out_full,
    output logic                           o_fire,
    output mpo_pkg::t_out_item             o_result
);
    import mpo_pkg::*;

    localparam int CW = ((DAC_BITS > STEP_W) ? DAC_BITS : STEP_W) + 2;

    t_cfg                        r_cfg;
    logic signed [SUM_WIDTH-1:0] r_sum, n_sum;
    logic signed [SUM_WIDTH-1:0] r_prev, n_prev;
    logic                        r_dir, n_dir;
    logic                        r_prev_dir, n_prev_dir;
    logic [RUN_W-1:0]            r_run, n_run;
    logic [STEP_W-1:0]           r_step, n_step;
    logic [DAC_BITS-1:0]         r_dac, n_dac;

    logic signed [SUM_WIDTH:0]   sum_ext;
    logic signed [SUM_WIDTH-1:0] sum_sat;
    logic                        fell;
    logic [CW-1:0]               level_ext, step_ext, up_sum, hi_ext, lo_ext, floor_at;
    logic [CW-1:0]               lvl_d, out_lvl_ext;
    logic                        go_down;

    assign o_fire = i_op_valid && !i_out_full;

    always_comb begin
        sum_ext = $signed({r_sum[SUM_WIDTH-1], r_sum}) + (SUM_WIDTH + 1)'(i_op.product);
        if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
            sum_sat = sum_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH - 1){1'b0}}}
                                         : {1'b0, {(SUM_WIDTH - 1){1'b1}}};
        end else begin
            sum_sat = sum_ext[SUM_WIDTH-1:0];
        end
    end

    assign fell = (r_sum < r_prev);

    always_comb begin
        n_sum      = r_sum;
        n_prev     = r_prev;
        n_dir      = r_dir;
        n_prev_dir = r_prev_dir;
        n_run      = r_run;
        n_step     = r_step;
        n_dac      = r_dac;
        level_ext  = '0;
        step_ext   = '0;
        up_sum     = '0;
        hi_ext     = '0;
        lo_ext     = '0;
        floor_at   = '0;
        lvl_d      = '0;
        go_down    = 1'b0;
        if (!i_op.decide) begin
            n_sum = sum_sat;
        end else begin
            if (fell) begin
                n_dir = !r_dir;
                n_run = '0;
            end else if (r_run < RUN_MAX) begin
                n_run = r_run + 1'b1;
            end

            if (n_dir == r_prev_dir) begin
                if (n_run == RUN_MAX) begin
                    if (r_step < {1'b0, r_cfg.step_high}) begin
                        n_step = r_step << 1;
                    end
                    n_run = '0;
                end
            end else begin
                if (r_step > {1'b0, r_cfg.step_low}) begin
                    n_step = r_step >> 1;
                end
                n_prev_dir = n_dir;
            end

            level_ext = CW'(r_dac);
            step_ext  = CW'(n_step);
            hi_ext    = CW'(r_cfg.dac_high);
            lo_ext    = CW'(r_cfg.dac_low);
            up_sum    = level_ext + step_ext;
            floor_at  = step_ext + lo_ext;
            if (n_dir) begin
                lvl_d = (up_sum < hi_ext) ? up_sum : hi_ext;
            end else begin
                go_down = (r_cfg.pin_mode == PIN_MODE_EN) ? (level_ext > floor_at)
                                                          : (level_ext >= floor_at);
                lvl_d   = go_down ? (level_ext - step_ext) : lo_ext;
            end
            n_dac  = lvl_d[DAC_BITS-1:0];
            n_prev = r_sum;
            n_sum  = '0;
        end
    end

    assign out_lvl_ext = CW'(n_dac);

    always_comb begin
        o_result.drive_level = out_lvl_ext[LEVEL_W-1:0];
        o_result.step_now    = n_step;
        o_result.moving_up   = n_dir;
        o_result.power_fell  = i_op.decide && fell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dac_low   <= RST_DAC_LOW;
            r_cfg.dac_high  <= RST_DAC_HIGH;
            r_cfg.step_low  <= RST_STEP_LOW;
            r_cfg.step_high <= RST_STEP_HIGH;
            r_cfg.pin_mode  <= PIN_MODE_SS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DAC_LOW:     r_cfg.dac_low   <= i_cfg_data;
                CFG_DAC_HIGH:    r_cfg.dac_high  <= i_cfg_data;
                CFG_STEP_LOW:    r_cfg.step_low  <= i_cfg_data;
                CFG_STEP_HIGH:   r_cfg.step_high <= i_cfg_data;
                // not stored: a write here is ignored, and reset loads the fixed RST_START level
                CFG_START_LEVEL: ;
                CFG_PIN_MODE:    r_cfg.pin_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_prev     <= '0;
            r_dir      <= 1'b1;
            r_prev_dir <= 1'b1;
            r_run      <= '0;
            r_step     <= {1'b0, RST_STEP_LOW};
            r_dac      <= DAC_BITS'(RST_START);
        end else if (o_fire) begin
            r_sum      <= n_sum;
            r_prev     <= n_prev;
            r_dir      <= n_dir;
            r_prev_dir <= n_prev_dir;
            r_run      <= n_run;
            r_step     <= n_step;
            r_dac      <= n_dac;
        end
    end

endmodule

// ===== design/mppt_perturb_observe_adaptive_step.sv =====
// ----------------------------------------------------------------------------
// mppt_perturb_observe_adaptive_step
// Perturb-and-observe power point tracker with adaptive step size.
//
//   channel  direction  handshake        payload
//   input    in         push / full      i_in_item  (t_in_item)
//   result   out        pop / empty      o_out_item (t_out_item)
//   config   in         i_cfg_we         i_cfg_idx, i_cfg_data
//
// One transaction per cycle sustained in both directions while neither side stalls.
// An input reaches the output through two queues: the multiply feeds the op queue,
// then one sample or decision step in the back end feeds the result queue.
// Reset clears both queues and loads the state and limit registers.
// A stalled result queue holds the back end; full rises once the op queue fills.
// ----------------------------------------------------------------------------
module mppt_perturb_observe_adaptive_step #(
    parameter int SUM_WIDTH = 48,
    parameter int DAC_BITS  = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    input  mpo_pkg::t_in_item              i_in_item,
    output logic                           full,
    input  logic                           pop,
    output mpo_pkg::t_out_item             o_out_item,
    output logic                           empty,
    input  logic                           i_cfg_we,
    input  logic [mpo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mpo_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mpo_pkg::*;

    logic      op_push, op_full, op_empty, fire, out_full;
    t_op       op_in, op_out;
    t_out_item result;

    assign full = op_full;

    mpo_front u_front (
        .i_push       (push),
        .i_item       (i_in_item),
        .i_queue_full (op_full),
        .o_op_push    (op_push),
        .o_op         (op_in)
    );

    mpo_queue #(
        .WIDTH ($bits(t_op)),
        .DEPTH (OP_QUEUE_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  (op_in),
        .o_full  (op_full),
        .i_pop   (fire),
        .o_data  (op_out),
        .o_empty (op_empty)
    );

    mpo_back #(
        .SUM_WIDTH (SUM_WIDTH),
        .DAC_BITS  (DAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_op_valid (!op_empty),
        .i_op       (op_out),
        .i_out_full (out_full),
        .o_fire     (fire),
        .o_result   (result)
    );

    mpo_queue #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (result),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty)
    );

endmodule

// ===== design/mpo_checker.sv =====
// ----------------------------------------------------------------------------
// mpo_checker
// Port-level checks of the tracker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module mpo_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           push,
    input logic                           full,
    input logic                           pop,
    input mpo_pkg::t_out_item             o_out_item,
    input logic                           empty,
    input logic                           i_cfg_we
);
    import mpo_pkg::*;

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |-> ##2 !empty)
        else $error("accepted transaction produced no result in time");

    a_result_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("waiting result changed or vanished");

    a_no_cfg_mid_flight : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> !($past(i_cfg_we) && i_cfg_we && full))
        else $error("configuration write overlapped a stalled input");

endmodule

bind mppt_perturb_observe_adaptive_step mpo_checker u_mpo_checker (.*);

// ===== verif/mppt_perturb_observe_adaptive_step_tb.sv =====
// ----------------------------------------------------------------------------
// mppt_perturb_observe_adaptive_step_tb
// Self-checking bench for the perturb-and-observe tracker. A scoreboard
// object keeps its own copy of the tracker state and limit registers,
// predicts one result per accepted transaction and compares every popped
// result field by field. Stimulus runs a short directed part, then phases of
// trend-shaped sample/decide traffic under several register settings and
// idle patterns, full-scale runs of both signs and a zero-step run.
// ----------------------------------------------------------------------------
module mppt_perturb_observe_adaptive_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpo_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int SAT_RUN     = 30;
    localparam int PRINT_CAP   = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 64'sd1;

    class tracker_board;
        logic [REG_W-1:0]   dac_low, dac_high, step_low, step_high, start_lvl;
        logic               pin_mode;
        longint             acc_sum, last_sum;
        logic               dir_up, prev_dir_up;
        logic [RUN_W-1:0]   run_cnt;
        logic [STEP_W-1:0]  step_sz;
        logic [LEVEL_W-1:0] dac_lvl;
        t_out_item          expected_track[$];
        int                 errors;

        function new();
            dac_low     = RST_DAC_LOW;
            dac_high    = RST_DAC_HIGH;
            step_low    = RST_STEP_LOW;
            step_high   = RST_STEP_HIGH;
            start_lvl   = RST_START;
            pin_mode    = PIN_MODE_SS;
            acc_sum     = 0;
            last_sum    = 0;
            dir_up      = 1'b1;
            prev_dir_up = 1'b1;
            run_cnt     = '0;
            step_sz     = STEP_W'(RST_STEP_LOW);
            dac_lvl     = RST_START;
            errors      = 0;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DAC_LOW:     dac_low   = data;
                CFG_DAC_HIGH:    dac_high  = data;
                CFG_STEP_LOW:    step_low  = data;
                CFG_STEP_HIGH:   step_high = data;
                CFG_START_LEVEL: start_lvl = data;
                CFG_PIN_MODE:    pin_mode  = data[0];
                default: ;
            endcase
        endfunction

        function void predict_track(t_in_item it);
            t_out_item exp_o;
            longint    product;
            int        shunt;
            int        bus;
            int        floor_at;
            logic      fell;
            fell = 1'b0;
            if (it.req_type == REQ_SAMPLE) begin
                shunt   = {{16{it.shunt_sample[15]}}, it.shunt_sample};
                bus     = {16'd0, it.bus_sample};
                product = longint'(shunt) * longint'(bus);
                acc_sum = acc_sum + product;
                if (acc_sum > SUM_HI) acc_sum = SUM_HI;
                else if (acc_sum < SUM_LO) acc_sum = SUM_LO;
            end else begin
                if (acc_sum < last_sum) begin
                    fell    = 1'b1;
                    dir_up  = ~dir_up;
                    run_cnt = '0;
                end else if (run_cnt < RUN_MAX) begin
                    run_cnt = run_cnt + 1'b1;
                end
                if (dir_up == prev_dir_up) begin
                    if (run_cnt >= RUN_MAX) begin
                        if (int'(step_sz) < int'(step_high)) step_sz = step_sz << 1;
                        run_cnt = '0;
                    end
                end else begin
                    if (int'(step_sz) > int'(step_low)) step_sz = step_sz >> 1;
                    prev_dir_up = dir_up;
                end
                if (dir_up) begin
                    if (int'(dac_lvl) + int'(step_sz) < int'(dac_high))
                        dac_lvl = dac_lvl + LEVEL_W'(step_sz);
                    else
                        dac_lvl = dac_high;
                end else begin
                    floor_at = int'(step_sz) + int'(dac_low);
                    if (pin_mode == PIN_MODE_EN ? int'(dac_lvl) > floor_at
                                                : int'(dac_lvl) >= floor_at)
                        dac_lvl = dac_lvl - LEVEL_W'(step_sz);
                    else
                        dac_lvl = dac_low;
                end
                last_sum = acc_sum;
                acc_sum  = 0;
            end
            exp_o.drive_level = dac_lvl;
            exp_o.step_now    = step_sz;
            exp_o.moving_up   = dir_up;
            exp_o.power_fell  = fell;
            expected_track.push_back(exp_o);
        endfunction

        function int pending();
            return expected_track.size();
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP) $display("tb: mismatch: %s", msg);
            errors++;
        endtask

        task check_output(t_out_item got);
            t_out_item want;
            if (expected_track.size() == 0) begin
                report($sformatf("result %h with nothing expected", got));
                return;
            end
            want = expected_track.pop_front();
            if (got.drive_level !== want.drive_level)
                report($sformatf("drive_level %0d, expected %0d",
                                 got.drive_level, want.drive_level));
            if (got.step_now !== want.step_now)
                report($sformatf("step_now %0d, expected %0d", got.step_now, want.step_now));
            if (got.moving_up !== want.moving_up)
                report($sformatf("moving_up %b, expected %b", got.moving_up, want.moving_up));
            if (got.power_fell !== want.power_fell)
                report($sformatf("power_fell %b, expected %b",
                                 got.power_fell, want.power_fell));
        endtask
    endclass

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  push     = 1'b0;
    logic                  pop      = 1'b0;
    t_in_item              in_item  = '0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  full;
    logic                  empty;
    t_out_item             out_item;

    tracker_board board;
    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    logic         hold_request  = 1'b0;
    int           quiet         = 0;
    int           trend         = 0;
    logic         trend_up      = 1'b1;

    mppt_perturb_observe_adaptive_step DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_in_item  (in_item),
        .full       (full),
        .pop        (pop),
        .o_out_item (out_item),
        .empty      (empty),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push    <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.predict_track(it);
    endtask

    task automatic send_fields(logic req, logic [15:0] shunt, logic [15:0] bus);
        t_in_item it;
        it.req_type     = req;
        it.shunt_sample = shunt;
        it.bus_sample   = bus;
        send_item(it);
    endtask

    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        board.note_config(idx, data);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [REG_W-1:0] lo, hi, slo, shi, start, logic mode);
        settle();
        write_reg(CFG_DAC_LOW, lo);
        write_reg(CFG_DAC_HIGH, hi);
        write_reg(CFG_STEP_LOW, slo);
        write_reg(CFG_STEP_HIGH, shi);
        write_reg(CFG_START_LEVEL, start);
        write_reg(CFG_PIN_MODE, CFG_DATA_W'(mode));
    endtask

    task automatic configure_random();
        configure(12'($urandom_range(2047)), 12'($urandom_range(4095, 2048)),
                  12'($urandom_range(8, 1)), 12'($urandom_range(300, 1)),
                  12'($urandom), 1'($urandom));
    endtask

    // Bursts of samples that follow a drifting power trend, then a decision
    task automatic run_traffic(int count);
        t_in_item it;
        int       sent;
        int       burst;
        sent = 0;
        while (sent < count) begin
            burst = ($urandom_range(6) == 0) ? int'($urandom_range(4)) : 2;
            if ($urandom_range(5) == 0) trend_up = ~trend_up;
            trend += trend_up ? int'($urandom_range(400)) : -int'($urandom_range(400));
            if (trend > 30000) trend = 30000;
            if (trend < -30000) trend = -30000;
            repeat (burst) begin
                if (sent < count) begin
                    if ($urandom_range(9) == 0) begin
                        it.req_type     = 1'($urandom_range(1));
                        it.shunt_sample = 16'($urandom);
                        it.bus_sample   = 16'($urandom);
                    end else begin
                        it.req_type     = REQ_SAMPLE;
                        it.shunt_sample = 16'(trend + int'($urandom_range(64)) - 32);
                        it.bus_sample   = 16'(40000 + $urandom_range(4000));
                    end
                    send_item(it);
                    sent++;
                end
            end
            if (sent < count) begin
                it.req_type     = REQ_DECIDE;
                it.shunt_sample = 16'($urandom);
                it.bus_sample   = 16'($urandom);
                send_item(it);
                sent++;
            end
        end
    endtask

    initial begin : result_drain
        int held;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                pop <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) board.check_output(out_item);
            if ((push && !full) || (pop && !empty)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QUIET_LIMIT) begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        int k;
        board = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full-scale products, a reversal, then steady decisions to double the step
        send_fields(REQ_SAMPLE, 16'h7FFF, 16'hFFFF);
        send_fields(REQ_DECIDE, 16'h0000, 16'h0000);
        send_fields(REQ_SAMPLE, 16'h8000, 16'hFFFF);
        send_fields(REQ_DECIDE, 16'hFFFF, 16'hFFFF);
        send_fields(REQ_SAMPLE, 16'h0000, 16'hFFFF);
        send_fields(REQ_SAMPLE, 16'hFFFF, 16'h0001);
        repeat (8) send_fields(REQ_DECIDE, 16'h0000, 16'h0000);

        // narrow window: clamp at both limits, ignore spare indexes
        configure(12'd2040, 12'd2046, 12'd1, 12'd4095, 12'd0, PIN_MODE_EN);
        write_reg(CFG_SPARE_LO, 12'($urandom));
        write_reg(CFG_SPARE_HI, 12'hFFF);
        send_fields(REQ_SAMPLE, 16'h7FFF, 16'h0001);
        send_fields(REQ_DECIDE, 16'h0000, 16'h0000);
        send_fields(REQ_DECIDE, 16'h0000, 16'h0000);
        send_fields(REQ_SAMPLE, 16'h8000, 16'h8000);
        send_fields(REQ_DECIDE, 16'h0000, 16'h0000);
        repeat (4) send_fields(REQ_DECIDE, 16'h0000, 16'h0000);

        configure(12'd0, 12'd4095, 12'd1, 12'd4095, 12'd0, PIN_MODE_SS);
        run_traffic(250);

        send_idle_pct = 86;
        configure(12'd0, 12'd4095, 12'd1, 12'd8, 12'd4095, PIN_MODE_EN);
        run_traffic(250);

        send_idle_pct = 0;
        stall_pct     = 86;
        configure(12'd1000, 12'd1064, 12'd1, 12'd64, 12'd2048, PIN_MODE_SS);
        run_traffic(250);

        send_idle_pct = 10;
        stall_pct     = 10;
        configure(12'd4095, 12'd0, 12'd4095, 12'd1, 12'd0, PIN_MODE_EN);
        run_traffic(200);

        // hold the result side while offering, then pause until drained
        send_idle_pct = 0;
        stall_pct     = 0;
        configure_random();
        run_traffic(100);
        hold_request = 1'b1;
        run_traffic(100);
        settle();
        run_traffic(100);

        send_idle_pct = 10;
        stall_pct     = 10;
        configure_random();
        run_traffic(200);

        // long runs of full-scale products of both signs
        send_idle_pct = 0;
        stall_pct     = 0;
        configure(12'd0, 12'd4095, 12'd1, 12'd4095, 12'd2048, PIN_MODE_SS);
        repeat (SAT_RUN) send_fields(REQ_SAMPLE, 16'h7FFF, 16'hFFFF);
        send_fields(REQ_DECIDE, 16'h0000, 16'h0000);
        repeat (SAT_RUN) send_fields(REQ_SAMPLE, 16'h8000, 16'hFFFF);
        send_fields(REQ_DECIDE, 16'h0000, 16'h0000);
        send_fields(REQ_DECIDE, 16'h0000, 16'h0000);

        // halve the step down to zero with a falling sum on every decision but the first
        configure(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd2048, PIN_MODE_EN);
        for (k = 0; k < 16; k++) begin
            send_fields(REQ_SAMPLE, 16'(32000 - 4000 * k), 16'hFFFF);
            send_fields(REQ_DECIDE, 16'h0000, 16'h0000);
        end
        run_traffic(40);

        settle();
        repeat (8) @(posedge i_clk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mpo_pkg.sv
design/mpo_queue.sv
design/mpo_front.sv
design/mpo_back.sv
design/mppt_perturb_observe_adaptive_step.sv
design/mpo_checker.sv
verif/mppt_perturb_observe_adaptive_step_tb.sv
